### sv/lrpp_pkg.sv
package lrpp_pkg;

    // table geometry, fixed by the field widths
    localparam int MaxInstr = 1024;
    localparam int AddrW    = 10;
    localparam int CntW     = 11;
    localparam int EndDepth = MaxInstr + 1;
    localparam int CfgIdxW  = 3;

    // request codes
    localparam logic [1:0] ReqDefine = 2'd0;
    localparam logic [1:0] ReqUse    = 2'd1;
    localparam logic [1:0] ReqFinish = 2'd2;

    // value class codes
    localparam logic [1:0] ClsNone  = 2'd0;
    localparam logic [1:0] ClsInt   = 2'd1;
    localparam logic [1:0] ClsFloat = 2'd2;

    // pressure level codes
    localparam logic [1:0] LvlLow      = 2'd0;
    localparam logic [1:0] LvlElevated = 2'd1;
    localparam logic [1:0] LvlHigh     = 2'd2;
    localparam logic [1:0] LvlUnknown  = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgScanLimit   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgGprElevated = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgGprHigh     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFprElevated = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgFprHigh     = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_USE_WR,
        ST_SW_RD,
        ST_SW_EVAL,
        ST_SW_INC,
        ST_REPORT
    } ctrl_state_t;

    // last-use entry: used flag plus last user position
    typedef struct packed {
        logic             used;
        logic [AddrW-1:0] last;
    } lu_entry_t;

    // count of integer and float intervals ending just before a position
    typedef struct packed {
        logic [CntW-1:0] g;
        logic [CntW-1:0] f;
    } end_entry_t;

    typedef struct packed {
        logic             cls_we;
        logic [AddrW-1:0] cls_waddr;
        logic [1:0]       cls_wdata;
        logic [AddrW-1:0] cls_raddr;
        logic             lu_we;
        logic [AddrW-1:0] lu_waddr;
        lu_entry_t        lu_wdata;
        logic [AddrW-1:0] lu_raddr;
        logic             end_we;
        logic [CntW-1:0]  end_waddr;
        end_entry_t       end_wdata;
        logic [CntW-1:0]  end_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] cls_rdata;
        lu_entry_t  lu_rdata;
        end_entry_t end_rdata;
    } mem_rsp_t;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            big;
        logic [CntW-1:0] peak_g;
        logic [CntW-1:0] peak_f;
    } sweep_res_t;

endpackage

### sv/lrpp_store.sv
module lrpp_store (
    input  logic              clk,
    input  lrpp_pkg::mem_req_t req,
    output lrpp_pkg::mem_rsp_t rsp
);

    logic [1:0]           cls_mem [0:lrpp_pkg::MaxInstr-1];
    lrpp_pkg::lu_entry_t  lu_mem  [0:lrpp_pkg::MaxInstr-1];
    lrpp_pkg::end_entry_t end_mem [0:lrpp_pkg::EndDepth-1];

    logic [1:0]           cls_rdata_reg;
    lrpp_pkg::lu_entry_t  lu_rdata_reg;
    lrpp_pkg::end_entry_t end_rdata_reg;

    // value class per instruction
    always_ff @(posedge clk)
    begin
        if (req.cls_we)
        begin
            cls_mem[req.cls_waddr] <= req.cls_wdata;
        end
        cls_rdata_reg <= cls_mem[req.cls_raddr];
    end

    // used flag and last use per instruction
    always_ff @(posedge clk)
    begin
        if (req.lu_we)
        begin
            lu_mem[req.lu_waddr] <= req.lu_wdata;
        end
        lu_rdata_reg <= lu_mem[req.lu_raddr];
    end

    // interval end counts per position
    always_ff @(posedge clk)
    begin
        if (req.end_we)
        begin
            end_mem[req.end_waddr] <= req.end_wdata;
        end
        end_rdata_reg <= end_mem[req.end_raddr];
    end

    assign rsp.cls_rdata = cls_rdata_reg;
    assign rsp.lu_rdata  = lu_rdata_reg;
    assign rsp.end_rdata = end_rdata_reg;

endmodule

### sv/lrpp_ctrl.sv
module lrpp_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [1:0]                          value_class,
    input  logic [lrpp_pkg::AddrW-1:0]          user_position,
    input  logic [lrpp_pkg::AddrW-1:0]          operand_position,
    input  logic [lrpp_pkg::CntW-1:0]           scan_limit,
    input  logic                                out_free,
    output logic                                res_load,
    output lrpp_pkg::sweep_res_t                res,
    output lrpp_pkg::mem_req_t                  mem_req,
    input  lrpp_pkg::mem_rsp_t                  mem_rsp
);

    localparam int CntW  = lrpp_pkg::CntW;
    localparam int AddrW = lrpp_pkg::AddrW;

    lrpp_pkg::ctrl_state_t state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [CntW-1:0]  idx_reg, idx_next;
    logic [AddrW-1:0] user_reg, user_next;
    logic [AddrW-1:0] opnd_reg, opnd_next;
    logic             use_ok_reg, use_ok_next;
    logic             big_reg, big_next;
    logic [CntW-1:0]  live_g_reg, live_g_next;
    logic [CntW-1:0]  live_f_reg, live_f_next;
    logic [CntW-1:0]  peak_g_reg, peak_g_next;
    logic [CntW-1:0]  peak_f_reg, peak_f_next;
    logic [CntW-1:0]  tgt_reg, tgt_next;
    logic             tgt_int_reg, tgt_int_next;

    // sweep step terms
    logic             at_end;
    logic             is_start;
    logic             start_g;
    logic             start_f;
    logic [CntW-1:0]  last_ext;
    logic [CntW-1:0]  last_clamp;
    logic [CntW-1:0]  tgt;
    logic [CntW-1:0]  live_g_new;
    logic [CntW-1:0]  live_f_new;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lrpp_pkg::ST_CLEAR;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            use_ok_reg   <= 1'b0;
            big_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            idx_reg      <= idx_next;
            use_ok_reg   <= use_ok_next;
            big_reg      <= big_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        user_reg    <= user_next;
        opnd_reg    <= opnd_next;
        live_g_reg  <= live_g_next;
        live_f_reg  <= live_f_next;
        peak_g_reg  <= peak_g_next;
        peak_f_reg  <= peak_f_next;
        tgt_reg     <= tgt_next;
        tgt_int_reg <= tgt_int_next;
    end

    // one sweep position: start test, interval end clamp, live update
    always_comb
    begin
        at_end   = (idx_reg == count_reg);
        is_start = !at_end && !big_reg && mem_rsp.lu_rdata.used &&
                   (mem_rsp.cls_rdata == lrpp_pkg::ClsInt ||
                    mem_rsp.cls_rdata == lrpp_pkg::ClsFloat);
        start_g  = is_start && (mem_rsp.cls_rdata == lrpp_pkg::ClsInt);
        start_f  = is_start && (mem_rsp.cls_rdata == lrpp_pkg::ClsFloat);
        last_ext = {1'b0, mem_rsp.lu_rdata.last};
        if (last_ext < idx_reg)
        begin
            last_clamp = idx_reg;
        end
        else if (last_ext >= count_reg)
        begin
            last_clamp = count_reg - CntW'(1);
        end
        else
        begin
            last_clamp = last_ext;
        end
        tgt        = last_clamp + CntW'(1);
        live_g_new = live_g_reg - mem_rsp.end_rdata.g + CntW'(start_g);
        live_f_new = live_f_reg - mem_rsp.end_rdata.f + CntW'(start_f);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        idx_next      = idx_reg;
        user_next     = user_reg;
        opnd_next     = opnd_reg;
        use_ok_next   = use_ok_reg;
        big_next      = big_reg;
        live_g_next   = live_g_reg;
        live_f_next   = live_f_reg;
        peak_g_next   = peak_g_reg;
        peak_f_next   = peak_f_reg;
        tgt_next      = tgt_reg;
        tgt_int_next  = tgt_int_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;

        mem_req           = '0;
        mem_req.cls_raddr = idx_reg[AddrW-1:0];
        mem_req.lu_raddr  = idx_reg[AddrW-1:0];
        mem_req.end_raddr = idx_reg;

        case (state_reg)
            lrpp_pkg::ST_CLEAR:
            begin
                // zero the end counts and used flags after reset
                mem_req.end_we    = 1'b1;
                mem_req.end_waddr = idx_reg;
                mem_req.lu_we     = !idx_reg[CntW-1];
                mem_req.lu_waddr  = idx_reg[AddrW-1:0];
                if (idx_reg == CntW'(lrpp_pkg::MaxInstr))
                begin
                    idx_next   = '0;
                    state_next = lrpp_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CntW'(1);
                end
            end

            lrpp_pkg::ST_IDLE:
            begin
                in_ready         = 1'b1;
                mem_req.lu_raddr = operand_position;
                if (in_valid)
                begin
                    case (req_type)
                        lrpp_pkg::ReqDefine:
                        begin
                            if (count_reg < CntW'(lrpp_pkg::MaxInstr))
                            begin
                                mem_req.cls_we    = 1'b1;
                                mem_req.cls_waddr = count_reg[AddrW-1:0];
                                mem_req.cls_wdata = value_class;
                                count_next        = count_reg + CntW'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        lrpp_pkg::ReqUse:
                        begin
                            user_next   = user_position;
                            opnd_next   = operand_position;
                            use_ok_next = ({1'b0, user_position} < count_reg) &&
                                          ({1'b0, operand_position} < count_reg);
                            state_next  = lrpp_pkg::ST_USE_WR;
                        end
                        lrpp_pkg::ReqFinish:
                        begin
                            big_next    = overflow_reg || (count_reg > scan_limit);
                            idx_next    = '0;
                            live_g_next = '0;
                            live_f_next = '0;
                            peak_g_next = '0;
                            peak_f_next = '0;
                            state_next  = lrpp_pkg::ST_SW_RD;
                        end
                        default:
                        begin
                            state_next = lrpp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lrpp_pkg::ST_USE_WR:
            begin
                // raise last use of the operand
                if (use_ok_reg && (!mem_rsp.lu_rdata.used ||
                                   mem_rsp.lu_rdata.last < user_reg))
                begin
                    mem_req.lu_we         = 1'b1;
                    mem_req.lu_waddr      = opnd_reg;
                    mem_req.lu_wdata.used = 1'b1;
                    mem_req.lu_wdata.last = user_reg;
                end
                state_next = lrpp_pkg::ST_IDLE;
            end

            lrpp_pkg::ST_SW_RD:
            begin
                state_next = lrpp_pkg::ST_SW_EVAL;
            end

            lrpp_pkg::ST_SW_EVAL:
            begin
                live_g_next = live_g_new;
                live_f_next = live_f_new;
                if (live_g_new > peak_g_reg)
                begin
                    peak_g_next = live_g_new;
                end
                if (live_f_new > peak_f_reg)
                begin
                    peak_f_next = live_f_new;
                end
                // position consumed: clear its end count and used flag
                mem_req.end_we    = 1'b1;
                mem_req.end_waddr = idx_reg;
                mem_req.lu_we     = !at_end;
                mem_req.lu_waddr  = idx_reg[AddrW-1:0];
                if (at_end)
                begin
                    state_next = lrpp_pkg::ST_REPORT;
                end
                else if (is_start)
                begin
                    mem_req.end_raddr = tgt;
                    tgt_next          = tgt;
                    tgt_int_next      = start_g;
                    state_next        = lrpp_pkg::ST_SW_INC;
                end
                else
                begin
                    idx_next   = idx_reg + CntW'(1);
                    state_next = lrpp_pkg::ST_SW_RD;
                end
            end

            lrpp_pkg::ST_SW_INC:
            begin
                // count one more interval ending before the target
                mem_req.end_we      = 1'b1;
                mem_req.end_waddr   = tgt_reg;
                mem_req.end_wdata.g = mem_rsp.end_rdata.g + CntW'(tgt_int_reg);
                mem_req.end_wdata.f = mem_rsp.end_rdata.f + CntW'(!tgt_int_reg);
                idx_next            = idx_reg + CntW'(1);
                state_next          = lrpp_pkg::ST_SW_RD;
            end

            lrpp_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = lrpp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lrpp_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.count  = count_reg;
    assign res.big    = big_reg;
    assign res.peak_g = peak_g_reg;
    assign res.peak_f = peak_f_reg;

endmodule

### sv/live_range_peak_pressure.sv
// Peak register pressure for one function. Define items number instructions in
// arrival order; use items read and then update the operand's last use. A finish
// item walks positions 0 to n through the block RAMs for n instructions; each
// position is read and then evaluated, and every value that is counted adds a
// read-modify-write of the end-count memory. The walk also clears the end counts
// and used flags. The table reads are registered, the walk takes one position at a
// time, and a single end-count memory serves both the walk and its increments. After
// reset a clearing pass zeroes the end counts and used flags before the first item
// is accepted; configuration writes are taken at any time. A result waits in an
// output register, and define and use items are accepted while it waits.
module live_range_peak_pressure (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lrpp_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [lrpp_pkg::CntW-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic [1:0]                         value_class,
    input  logic [lrpp_pkg::AddrW-1:0]         user_position,
    input  logic [lrpp_pkg::AddrW-1:0]         operand_position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lrpp_pkg::CntW-1:0]          instruction_count,
    output logic                               too_large,
    output logic [lrpp_pkg::CntW-1:0]          peak_gpr,
    output logic [lrpp_pkg::CntW-1:0]          peak_fpr,
    output logic [1:0]                         gpr_level,
    output logic [1:0]                         fpr_level,
    output logic [1:0]                         overall_level
);

    localparam int CntW = lrpp_pkg::CntW;

    logic [CntW-1:0] scan_limit_reg;
    logic [CntW-1:0] gpr_elevated_reg;
    logic [CntW-1:0] gpr_high_reg;
    logic [CntW-1:0] fpr_elevated_reg;
    logic [CntW-1:0] fpr_high_reg;

    logic            out_valid_reg;
    logic [CntW-1:0] count_reg;
    logic            big_reg;
    logic [CntW-1:0] peak_g_reg;
    logic [CntW-1:0] peak_f_reg;
    logic [1:0]      lvl_g_reg;
    logic [1:0]      lvl_f_reg;
    logic [1:0]      lvl_o_reg;

    logic                 out_free;
    logic                 res_load;
    lrpp_pkg::sweep_res_t res;
    lrpp_pkg::mem_req_t   mem_req;
    lrpp_pkg::mem_rsp_t   mem_rsp;
    logic [1:0]           lvl_g;
    logic [1:0]           lvl_f;
    logic [1:0]           lvl_o;

    function automatic logic [1:0] grade(input logic [CntW-1:0] peak,
                                         input logic [CntW-1:0] elevated,
                                         input logic [CntW-1:0] high);
        logic [1:0] lvl;
        if (peak >= high)
        begin
            lvl = lrpp_pkg::LvlHigh;
        end
        else if (peak >= elevated)
        begin
            lvl = lrpp_pkg::LvlElevated;
        end
        else
        begin
            lvl = lrpp_pkg::LvlLow;
        end
        return lvl;
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg   <= CntW'(1024);
            gpr_elevated_reg <= CntW'(16);
            gpr_high_reg     <= CntW'(24);
            fpr_elevated_reg <= CntW'(16);
            fpr_high_reg     <= CntW'(24);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lrpp_pkg::CfgScanLimit:   scan_limit_reg   <= cfg_data;
                lrpp_pkg::CfgGprElevated: gpr_elevated_reg <= cfg_data;
                lrpp_pkg::CfgGprHigh:     gpr_high_reg     <= cfg_data;
                lrpp_pkg::CfgFprElevated: fpr_elevated_reg <= cfg_data;
                lrpp_pkg::CfgFprHigh:     fpr_high_reg     <= cfg_data;
                default:                  scan_limit_reg   <= scan_limit_reg;
            endcase
        end
    end

    // grading of the finished sweep
    always_comb
    begin
        if (res.big)
        begin
            lvl_g = lrpp_pkg::LvlUnknown;
            lvl_f = lrpp_pkg::LvlUnknown;
        end
        else
        begin
            lvl_g = grade(res.peak_g, gpr_elevated_reg, gpr_high_reg);
            lvl_f = grade(res.peak_f, fpr_elevated_reg, fpr_high_reg);
        end
        lvl_o = (lvl_g >= lvl_f) ? lvl_g : lvl_f;
    end

    // result register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            count_reg  <= res.count;
            big_reg    <= res.big;
            peak_g_reg <= res.peak_g;
            peak_f_reg <= res.peak_f;
            lvl_g_reg  <= lvl_g;
            lvl_f_reg  <= lvl_f;
            lvl_o_reg  <= lvl_o;
        end
    end

    lrpp_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .value_class      (value_class),
        .user_position    (user_position),
        .operand_position (operand_position),
        .scan_limit       (scan_limit_reg),
        .out_free         (out_free),
        .res_load         (res_load),
        .res              (res),
        .mem_req          (mem_req),
        .mem_rsp          (mem_rsp)
    );

    lrpp_store u_store (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    assign out_valid         = out_valid_reg;
    assign instruction_count = count_reg;
    assign too_large         = big_reg;
    assign peak_gpr          = peak_g_reg;
    assign peak_fpr          = peak_f_reg;
    assign gpr_level         = lvl_g_reg;
    assign fpr_level         = lvl_f_reg;
    assign overall_level     = lvl_o_reg;

endmodule
